// ===== design/terrain_normal_packer_core_macros.svh =====
// Assertion macros shared by the checker of the terrain normal packer.
`ifndef TERRAIN_NORMAL_PACKER_CORE_MACROS_SVH
`define TERRAIN_NORMAL_PACKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TNP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tnp check failed");

// Next-cycle implication, disabled while reset is held.
`define TNP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tnp check failed");

`endif

// ===== design/tnp_pkg.sv =====
// Shared constants, codes and types of the terrain normal packer.
`default_nettype none
package tnp_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = COL_W + 1;
    localparam int ROW_W     = 16;
    localparam int ELEV_BITS = 16;
    localparam int GAIN_W    = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int XY_SCALE  = 1023;
    localparam int Z_SCALE   = 1023;

    // Arithmetic widths
    localparam int DIFF_W    = ELEV_BITS + 1;
    localparam int MAG_W     = ELEV_BITS;
    localparam int PROD_W    = MAG_W + GAIN_W + 1;
    localparam int SH_W      = 31;
    localparam int SHIFT_MAX = PROD_W - SH_W;
    localparam int SHIFT_W   = $clog2(SHIFT_MAX + 1);
    localparam int SQ_W      = 2 * SH_W;
    localparam int ACC_W     = 64;
    localparam int LEN_W     = 32;
    localparam int NUM_W     = LEN_W + 1;
    localparam int Q_W       = 11;
    localparam int DIV_STEPS = Q_W;
    localparam int DIVN_W    = NUM_W + 10;
    localparam int SQRT_STEPS = ACC_W / 2;
    localparam int SQ_TERMS  = 3;
    localparam int CNT_W     = $clog2(SQRT_STEPS + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLAT_TERM   = 3'd4;

    localparam logic [WIDTH_W-1:0] RST_GRID_WIDTH  = 11'd1024;
    localparam logic [ROW_W-1:0]   RST_GRID_HEIGHT = 16'd1024;
    localparam logic [GAIN_W-1:0]  RST_GAIN        = 24'd256;

    // Normal jobs of one sample, in emission order
    localparam logic [1:0] JOB_UPPER  = 2'd0;
    localparam logic [1:0] JOB_LEFT   = 2'd1;
    localparam logic [1:0] JOB_CORNER = 2'd2;
    localparam logic [1:0] JOB_DONE   = 2'd3;

    // Component selects
    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_Z = 2'd2;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_RD_CUR  = 12'b0000_0000_0010,
        S_RD_NEXT = 12'b0000_0000_0100,
        S_WR_LINE = 12'b0000_0000_1000,
        S_JOB_SEL = 12'b0000_0001_0000,
        S_LOAD    = 12'b0000_0010_0000,
        S_SCALE   = 12'b0000_0100_0000,
        S_SQUARE  = 12'b0000_1000_0000,
        S_SQRT    = 12'b0001_0000_0000,
        S_DIV     = 12'b0010_0000_0000,
        S_EMIT    = 12'b0100_0000_0000,
        S_FINISH  = 12'b1000_0000_0000
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       rd_cur;
        logic       rd_next;
        logic       wr_line;
        logic       load;
        logic [1:0] job;
        logic       scale;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_en;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic [1:0] div_sel;
        logic       emit;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic [3:0] job_valid;
        logic       out_free;
    } t_status;

endpackage
`default_nettype wire

// ===== design/tnp_sample_if.sv =====
// Request channel carrying elevation samples.
`default_nettype none
interface tnp_sample_if;
    import tnp_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [ELEV_BITS-1:0] elevation;
    modport source (output valid, output elevation, input ready);
    modport sink   (input valid, input elevation, output ready);
endinterface
`default_nettype wire

// ===== design/tnp_normal_if.sv =====
// Request channel carrying packed surface normals.
`default_nettype none
interface tnp_normal_if;
    import tnp_pkg::*;
    logic             valid;
    logic             ready;
    logic [31:0]      packed_normal;
    logic [ROW_W-1:0] point_row;
    logic [COL_W-1:0] point_col;
    logic             frame_last;
    modport source (output valid, output packed_normal, output point_row,
                    output point_col, output frame_last, input ready);
    modport sink   (input valid, input packed_normal, input point_row,
                    input point_col, input frame_last, output ready);
endinterface
`default_nettype wire

// ===== design/tnp_ctrl.sv =====
// Sequencer: line buffer access, per-normal job loop, sqrt and divide steps.
`default_nettype none
module tnp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tnp_pkg::t_status i_status,
    output tnp_pkg::t_cmd    o_cmd
);
    import tnp_pkg::*;

    t_state           r_state, n_state;
    logic [1:0]       r_job, n_job;
    logic [1:0]       r_dsel, n_dsel;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= JOB_UPPER;
            r_dsel  <= SEL_X;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            r_dsel  <= n_dsel;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        n_dsel     = r_dsel;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            // input closed while reset is held
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_RD_CUR;
                end
            end
            S_RD_CUR: begin
                o_cmd.rd_cur = 1'b1;
                n_state      = S_RD_NEXT;
            end
            S_RD_NEXT: begin
                o_cmd.rd_next = 1'b1;
                n_state       = S_WR_LINE;
            end
            S_WR_LINE: begin
                o_cmd.wr_line = 1'b1;
                n_job         = JOB_UPPER;
                n_state       = S_JOB_SEL;
            end
            S_JOB_SEL: begin
                if (r_job == JOB_DONE) begin
                    n_state = S_FINISH;
                end else if (i_status.job_valid[r_job]) begin
                    n_state = S_LOAD;
                end else begin
                    n_job = r_job + 2'd1;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                o_cmd.job  = r_job;
                n_state    = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_cnt       = '0;
                n_state     = S_SQUARE;
            end
            // one square per cycle, accumulated from its product register
            S_SQUARE: begin
                o_cmd.mul_en  = (r_cnt < CNT_W'(SQ_TERMS));
                o_cmd.mul_sel = r_cnt[1:0];
                o_cmd.acc_en  = (r_cnt != '0);
                if (r_cnt == CNT_W'(SQ_TERMS)) begin
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_init = (r_cnt == '0);
                o_cmd.sqrt_step = (r_cnt != '0);
                if (r_cnt == CNT_W'(SQRT_STEPS)) begin
                    n_cnt   = '0;
                    n_dsel  = SEL_X;
                    n_state = S_DIV;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_sel  = r_dsel;
                o_cmd.div_init = (r_cnt == '0);
                o_cmd.div_step = (r_cnt != '0);
                if (r_cnt == CNT_W'(DIV_STEPS)) begin
                    n_cnt = '0;
                    if (r_dsel == SEL_Z) begin
                        n_state = S_EMIT;
                    end else begin
                        n_dsel = r_dsel + 2'd1;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_job      = r_job + 2'd1;
                    n_state    = S_JOB_SEL;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/tnp_datapath.sv =====
// Line buffers, counters, config registers and the normal arithmetic.
`default_nettype none
module tnp_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tnp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tnp_pkg::CFG_W-1:0]           i_cfg_data,
    input  tnp_pkg::t_cmd                       i_cmd,
    output tnp_pkg::t_status                    o_status,
    input  logic signed [tnp_pkg::ELEV_BITS-1:0] i_elev,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [31:0]                         o_packed,
    output logic [tnp_pkg::ROW_W-1:0]           o_row,
    output logic [tnp_pkg::COL_W-1:0]           o_col,
    output logic                                o_last
);
    import tnp_pkg::*;

    // Configuration
    logic [WIDTH_W-1:0] r_grid_width;
    logic [ROW_W-1:0]   r_grid_height;
    logic [GAIN_W-1:0]  r_col_gain, r_row_gain, r_flat_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= RST_GRID_WIDTH;
            r_grid_height <= RST_GRID_HEIGHT;
            r_col_gain    <= RST_GAIN;
            r_row_gain    <= RST_GAIN;
            r_flat_term   <= RST_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[WIDTH_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_data[ROW_W-1:0];
                REG_COL_GAIN:    r_col_gain    <= i_cfg_data[GAIN_W-1:0];
                REG_ROW_GAIN:    r_row_gain    <= i_cfg_data[GAIN_W-1:0];
                REG_FLAT_TERM:   r_flat_term   <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped grid size
    logic [WIDTH_W-1:0] w_eff;
    logic [ROW_W-1:0]   h_eff;
    logic [COL_W-1:0]   col_end;
    logic [ROW_W-1:0]   row_end;
    assign w_eff = (r_grid_width < WIDTH_W'(2)) ? WIDTH_W'(2) :
                   (r_grid_width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : r_grid_width;
    assign h_eff   = (r_grid_height < ROW_W'(2)) ? ROW_W'(2) : r_grid_height;
    assign col_end = COL_W'(w_eff - WIDTH_W'(1));
    assign row_end = h_eff - ROW_W'(1);

    // Position counters
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             last_col, last_row, cfg_restart;
    assign last_col    = (r_col == col_end);
    assign last_row    = (r_row == row_end);
    assign cfg_restart = i_cfg_we &&
                         (i_cfg_idx == REG_GRID_WIDTH || i_cfg_idx == REG_GRID_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.accept) begin
            r_col <= ({1'b0, r_col} >= w_eff) ? col_end : r_col;
            r_row <= (r_row >= h_eff) ? row_end : r_row;
        end else if (i_cmd.finish) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Line buffer: {row R-2, row R-1} per column
    logic [2*ELEV_BITS-1:0]      line_mem [MAX_WIDTH];
    logic [2*ELEV_BITS-1:0]      r_rd;
    logic [COL_W-1:0]            rd_addr;
    logic signed [ELEV_BITS-1:0] r_e, r_up_c, r_old_c, r_up_n, r_left, r_rec0;

    assign rd_addr = i_cmd.rd_next ? r_col + COL_W'(1) : r_col;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_cur || i_cmd.rd_next) begin
            r_rd <= line_mem[rd_addr];
        end
        if (i_cmd.wr_line) begin
            line_mem[r_col] <= {r_up_c, r_e};
        end
    end

    // Sample and neighbor registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_e <= i_elev;
        end
        if (i_cmd.rd_next) begin
            r_up_c  <= r_rd[ELEV_BITS-1:0];
            r_old_c <= r_rd[2*ELEV_BITS-1:ELEV_BITS];
        end
        if (i_cmd.wr_line) begin
            r_up_n <= r_rd[ELEV_BITS-1:0];
        end
        if (i_cmd.finish) begin
            r_left <= r_up_c;
            r_rec0 <= r_e;
        end
    end

    // Difference selection per job
    logic                    inner;
    logic signed [DIFF_W-1:0] d_col, d_row;
    logic [DIFF_W-1:0]       a_col, a_row;
    logic [MAG_W-1:0]        m_col, m_row;
    logic [PROD_W-2:0]       p_col, p_row;
    logic [ROW_W-1:0]        j_row;
    logic [COL_W-1:0]        j_col;
    logic                    j_last, twice;

    assign inner = (r_row >= ROW_W'(2)) && (r_col != '0) && !last_col;

    always_comb begin
        d_col  = DIFF_W'(r_e) - DIFF_W'(r_rec0);
        d_row  = DIFF_W'(r_e) - DIFF_W'(r_up_c);
        j_row  = r_row;
        j_col  = r_col;
        j_last = 1'b0;
        twice  = 1'b0;
        case (i_cmd.job)
            JOB_UPPER: begin
                j_row = r_row - ROW_W'(1);
                twice = inner;
                if (inner) begin
                    d_col = DIFF_W'(r_up_n) - DIFF_W'(r_left);
                    d_row = DIFF_W'(r_e) - DIFF_W'(r_old_c);
                end else if (last_col) begin
                    d_col = DIFF_W'(r_up_c) - DIFF_W'(r_left);
                end else begin
                    d_col = DIFF_W'(r_up_n) - DIFF_W'(r_up_c);
                end
            end
            JOB_LEFT: begin
                d_row = DIFF_W'(r_rec0) - DIFF_W'(r_left);
                j_col = r_col - COL_W'(1);
            end
            JOB_CORNER: begin
                j_last = 1'b1;
            end
            default: ;
        endcase
    end

    assign a_col = d_col[DIFF_W-1] ? DIFF_W'(-d_col) : DIFF_W'(d_col);
    assign a_row = d_row[DIFF_W-1] ? DIFF_W'(-d_row) : DIFF_W'(d_row);
    assign m_col = a_col[MAG_W-1:0];
    assign m_row = a_row[MAG_W-1:0];
    assign p_col = m_col * r_col_gain;
    assign p_row = m_row * r_row_gain;

    // Magnitudes, scaling, squares
    logic [PROD_W-1:0] r_ax, r_ay, r_az, mag_or;
    logic              r_xneg, r_yneg;
    logic [ROW_W-1:0]  r_prow;
    logic [COL_W-1:0]  r_pcol;
    logic              r_plast;
    logic [SH_W-1:0]   r_x, r_y, r_z, sq_op;
    logic [SHIFT_W-1:0] sh;
    logic [SQ_W-1:0]   r_prod;
    logic [ACC_W-1:0]  r_acc;

    assign mag_or = r_ax | r_ay | r_az;

    always_comb begin
        sh = '0;
        for (int i = 0; i < SHIFT_MAX; i++) begin
            if (mag_or[SH_W+i]) begin
                sh = SHIFT_W'(i + 1);
            end
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            SEL_X:   sq_op = r_x;
            SEL_Y:   sq_op = r_y;
            default: sq_op = r_z;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax    <= twice ? {p_col, 1'b0} : {1'b0, p_col};
            r_ay    <= twice ? {p_row, 1'b0} : {1'b0, p_row};
            r_az    <= twice ? PROD_W'({r_flat_term, 1'b0}) : PROD_W'(r_flat_term);
            r_xneg  <= !d_col[DIFF_W-1] && (d_col != '0);
            r_yneg  <= d_row[DIFF_W-1];
            r_prow  <= j_row;
            r_pcol  <= j_col;
            r_plast <= j_last;
        end
        if (i_cmd.scale) begin
            r_x   <= SH_W'(r_ax >> sh);
            r_y   <= SH_W'(r_ay >> sh);
            r_z   <= SH_W'(r_az >> sh);
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.mul_en) begin
            r_prod <= sq_op * sq_op;
        end
    end

    // Bitwise square root, one result bit per cycle
    logic [ACC_W-1:0] r_srem, r_sres, r_sbit;
    logic [ACC_W:0]   s_trial;
    logic [LEN_W-1:0] len;

    assign s_trial = {1'b0, r_sres} + {1'b0, r_sbit};
    assign len     = (r_sres[LEN_W-1:0] == '0) ? LEN_W'(1) : r_sres[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_srem <= r_acc;
            r_sres <= '0;
            r_sbit <= ACC_W'(1) << (ACC_W - 2);
        end else if (i_cmd.sqrt_step) begin
            if ({1'b0, r_srem} >= s_trial) begin
                r_srem <= r_srem - s_trial[ACC_W-1:0];
                r_sres <= (r_sres >> 1) + r_sbit;
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end
    end

    // Restoring divider, one quotient bit per cycle
    logic [NUM_W-1:0]  d_num;
    logic [DIVN_W-1:0] d_scaled, r_drem, r_dvs;
    logic [Q_W-1:0]    r_qx, r_qy, r_qz;
    logic              d_ge;

    always_comb begin
        case (i_cmd.div_sel)
            SEL_X: begin
                d_num    = r_xneg ? NUM_W'(len) - NUM_W'(r_x) : NUM_W'(len) + NUM_W'(r_x);
                d_scaled = DIVN_W'(d_num) * DIVN_W'(XY_SCALE);
            end
            SEL_Y: begin
                d_num    = r_yneg ? NUM_W'(len) - NUM_W'(r_y) : NUM_W'(len) + NUM_W'(r_y);
                d_scaled = DIVN_W'(d_num) * DIVN_W'(XY_SCALE);
            end
            default: begin
                d_num    = NUM_W'(r_z);
                d_scaled = DIVN_W'(d_num) * DIVN_W'(Z_SCALE);
            end
        endcase
    end

    assign d_ge = (r_drem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_drem <= d_scaled;
            r_dvs  <= DIVN_W'(len) << (DIV_STEPS - 1);
            case (i_cmd.div_sel)
                SEL_X:   r_qx <= '0;
                SEL_Y:   r_qy <= '0;
                default: r_qz <= '0;
            endcase
        end else if (i_cmd.div_step) begin
            if (d_ge) begin
                r_drem <= r_drem - r_dvs;
            end
            r_dvs <= r_dvs >> 1;
            case (i_cmd.div_sel)
                SEL_X:   r_qx <= {r_qx[Q_W-2:0], d_ge};
                SEL_Y:   r_qy <= {r_qy[Q_W-2:0], d_ge};
                default: r_qz <= {r_qz[Q_W-2:0], d_ge};
            endcase
        end
    end

    // Output register
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_packed <= {r_qx, r_qy, r_qz[Q_W-2:0]};
            o_row    <= r_prow;
            o_col    <= r_pcol;
            o_last   <= r_plast;
        end
    end

    assign o_valid = r_ov;

    // Status to the sequencer
    assign o_status.job_valid = {1'b0, last_row && last_col,
                                 last_row && (r_col != '0), r_row != '0};
    assign o_status.out_free  = !r_ov || i_ready;

endmodule
`default_nettype wire

// ===== design/terrain_normal_packer_core.sv =====
// Terrain normal packer: samples arrive in raster order, and each one completes n
// (0 to 3) normals; per normal, a 32-step bitwise square root and three 11-step
// restoring divisions through one shared divider do the work, and each result
// waits for the result register to drain. Samples are taken one at a time; a
// finished normal sits in an output register while the next one is computed.
// Line buffers hold two rows of up to 1024 columns and
// are not cleared: normals that read a column never written hold no meaning.
// Writing grid_width or grid_height restarts the grid at row 0, column 0;
// configure only while the block is idle.
`default_nettype none
module terrain_normal_packer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tnp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tnp_pkg::CFG_W-1:0]     i_cfg_data,
    tnp_sample_if.sink                    i_sample,
    tnp_normal_if.source                  o_normal
);
    import tnp_pkg::*;

    t_cmd    cmd;
    t_status status;

    tnp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (i_sample.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tnp_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_elev     (i_sample.elevation),
        .o_valid    (o_normal.valid),
        .i_ready    (o_normal.ready),
        .o_packed   (o_normal.packed_normal),
        .o_row      (o_normal.point_row),
        .o_col      (o_normal.point_col),
        .o_last     (o_normal.frame_last)
    );

endmodule
`default_nettype wire

// ===== design/tnp_checker.sv =====
// Port-level checks of the terrain normal packer, bound to the top level.
`default_nettype none
`include "terrain_normal_packer_core_macros.svh"
module tnp_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_out_last,
    input logic [tnp_pkg::COL_W-1:0] i_out_col
);
    import tnp_pkg::*;

    // a stalled result stays offered
    `TNP_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    // one sample at a time: accepting a request closes the input
    `TNP_ASSERT_NEXT(a_in_single, i_in_valid && i_in_ready, !i_in_ready)
    // the frame ends at the last column, which is never column zero
    `TNP_ASSERT_NOW(a_last_col, i_out_valid && i_out_last, i_out_col != '0)

endmodule

bind terrain_normal_packer_core tnp_checker u_tnp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_normal.valid),
    .i_out_ready (o_normal.ready),
    .i_out_last  (o_normal.frame_last),
    .i_out_col   (o_normal.point_col)
);
`default_nettype wire
